>>> src/int8_dot_product_requantizer_macros.svh
// ----------------------------------------------------------------------------
// int8 dot product requantizer assertion macros
// Shared concurrent check helpers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_REQUANTIZER_MACROS_SVH
`define INT8_DOT_PRODUCT_REQUANTIZER_MACROS_SVH

// same-cycle implication
`define IDPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/idpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_pkg
// Types and fixed constants of the int8 dot product requantizer.
// ----------------------------------------------------------------------------
package idpr_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_INPUT_ZERO   = 3'd0,
		REG_OUTPUT_ZERO  = 3'd1,
		REG_SCALE_MULT   = 3'd2,
		REG_BIAS_ENABLE  = 3'd3,
		REG_RELU_ENABLE  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [7:0]  input_zero;
		logic signed [7:0]  output_zero;
		logic signed [31:0] scale_multiplier;
		logic               bias_enable;
		logic               relu_enable;
	} cfg_regs_t;

	// requantizer sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_BIAS,
		ST_MUL,
		ST_ROUND,
		ST_EMIT
	} back_state_t;

	localparam int BIAS_BITS   = 32;
	localparam int SCALE_BITS  = 32;
	localparam int Q_SHIFT     = 15;
	localparam int SCALED_BITS = 32;
	// product bits needed up to the top of the kept scaled word
	localparam int PROD_BITS   = Q_SHIFT + SCALED_BITS;
	localparam int CHUNK_BITS  = 16;
	localparam int PP_BITS     = CHUNK_BITS + 1 + SCALE_BITS;

	localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(16'h4000);
	localparam logic signed [7:0]    OUT_MAX    = 8'sd127;
	localparam logic signed [7:0]    OUT_MIN    = -8'sd128;

	localparam logic signed [31:0]   SCALE_RESET = 32'sd32768;

	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = 1;
	localparam int Q_CNT_BITS = 2;

endpackage

>>> src/idpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_front
// Multiply-accumulate front end: sums products and weights, hands each
// finished dot product to the queue on the last word.
// ----------------------------------------------------------------------------
module idpr_front #(
	parameter int ACC_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [7:0]                weight_value,
	input  logic signed [7:0]                activation_value,
	input  logic signed [31:0]               bias_value,
	input  logic                             is_last,
	input  logic                             q_full,
	output logic                             q_push,
	output logic [2*ACC_BITS+31:0]           q_data
);

	logic [ACC_BITS-1:0] product_sum_q;
	logic [ACC_BITS-1:0] weight_total_q;
	logic [ACC_BITS-1:0] product_sum_nxt;
	logic [ACC_BITS-1:0] weight_total_nxt;
	logic signed [15:0]  mac_product;
	logic                in_fire;

	assign mac_product      = weight_value * activation_value;
	assign product_sum_nxt  = product_sum_q + ACC_BITS'(mac_product);
	assign weight_total_nxt = weight_total_q + ACC_BITS'(weight_value);

	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;
	assign q_push   = in_fire && is_last;
	assign q_data   = {product_sum_nxt, weight_total_nxt, bias_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_sum_q  <= '0;
			weight_total_q <= '0;
		end else if (in_fire) begin
			if (is_last) begin
				product_sum_q  <= '0;
				weight_total_q <= '0;
			end else begin
				product_sum_q  <= product_sum_nxt;
				weight_total_q <= weight_total_nxt;
			end
		end
	end

endmodule

>>> src/idpr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_queue
// Two-entry queue of finished sums between the front and the requantizer.
// ----------------------------------------------------------------------------
module idpr_queue
	import idpr_pkg::*;
#(
	parameter int WIDTH = 96
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	output logic                  full,
	input  logic                  pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty,
	output logic [Q_CNT_BITS-1:0] count
);

	logic [WIDTH-1:0]      slot_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign count     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> src/idpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_back
// Requantizer: zero-point compensation, bias, Q15 scaling by 16-bit
// partial products, ReLU, output offset and int8 saturation.
// ----------------------------------------------------------------------------
module idpr_back
	import idpr_pkg::*;
#(
	parameter int ACC_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_regs_t               cfg,
	input  logic                    q_not_empty,
	input  logic [2*ACC_BITS+31:0]  q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [7:0]       result_value
);

	localparam int NCHUNK   = (ACC_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int EXT_BITS = NCHUNK * CHUNK_BITS;
	localparam int CNT_BITS = $clog2(NCHUNK);

	back_state_t state_q, state_nxt;

	logic [ACC_BITS-1:0]        ps_q;
	logic [ACC_BITS-1:0]        wt_q;
	logic signed [BIAS_BITS-1:0] bias_q;
	logic [ACC_BITS-1:0]        acc_q;
	logic [EXT_BITS-1:0]        sh_q;
	logic [CNT_BITS-1:0]        cnt_q;
	logic [PROD_BITS-1:0]       prod_q;
	logic signed [SCALED_BITS-1:0] scaled_q;
	logic                       out_valid_q;
	logic signed [7:0]          result_q;

	logic signed [ACC_BITS+7:0] comp_full;
	logic [ACC_BITS-1:0]        acc_biased;
	logic [CHUNK_BITS-1:0]      chunk;
	logic signed [CHUNK_BITS:0] chunk_s;
	logic signed [PP_BITS-1:0]  pp;
	logic [PROD_BITS-1:0]       prod_round;
	logic signed [SCALED_BITS-1:0] relu_val;
	logic signed [SCALED_BITS:0]   offset_val;
	logic signed [7:0]          sat_val;
	logic                       last_chunk;
	logic                       emit_ok;

	assign comp_full  = $signed(wt_q) * cfg.input_zero;
	assign acc_biased = cfg.bias_enable ? acc_q + ACC_BITS'(bias_q) : acc_q;

	// top chunk carries the sign, lower chunks are unsigned
	assign chunk      = sh_q[EXT_BITS-1 -: CHUNK_BITS];
	assign chunk_s    = {(cnt_q == '0) ? chunk[CHUNK_BITS-1] : 1'b0, chunk};
	assign pp         = chunk_s * cfg.scale_multiplier;
	assign last_chunk = (cnt_q == CNT_BITS'(NCHUNK - 1));

	assign prod_round = prod_q + ROUND_HALF;

	assign relu_val   = (cfg.relu_enable && scaled_q[SCALED_BITS-1]) ? '0 : scaled_q;
	assign offset_val = (SCALED_BITS+1)'(relu_val) + (SCALED_BITS+1)'(cfg.output_zero);

	always_comb begin
		if (offset_val > (SCALED_BITS+1)'(OUT_MAX))
			sat_val = OUT_MAX;
		else if (offset_val < (SCALED_BITS+1)'(OUT_MIN))
			sat_val = OUT_MIN;
		else
			sat_val = offset_val[7:0];
	end

	assign emit_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_not_empty) begin
					q_pop     = 1'b1;
					state_nxt = ST_COMP;
				end
			end
			ST_COMP:  state_nxt = ST_BIAS;
			ST_BIAS:  state_nxt = ST_MUL;
			ST_MUL: begin
				if (last_chunk)
					state_nxt = ST_ROUND;
			end
			ST_ROUND: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (emit_ok)
					state_nxt = ST_IDLE;
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ps_q   <= q_data[2*ACC_BITS+31 -: ACC_BITS];
				wt_q   <= q_data[ACC_BITS+31 -: ACC_BITS];
				bias_q <= q_data[BIAS_BITS-1:0];
			end
			ST_COMP: acc_q <= ps_q - comp_full[ACC_BITS-1:0];
			ST_BIAS: begin
				sh_q   <= EXT_BITS'($signed(acc_biased));
				prod_q <= '0;
				cnt_q  <= '0;
			end
			ST_MUL: begin
				// high chunk first, Horner style
				prod_q <= (prod_q << CHUNK_BITS) + pp[PROD_BITS-1:0];
				sh_q   <= sh_q << CHUNK_BITS;
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_ROUND: scaled_q <= prod_round[PROD_BITS-1 -: SCALED_BITS];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && emit_ok)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_ok)
			result_q <= sat_val;
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;

endmodule

>>> src/int8_dot_product_requantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_dot_product_requantizer
// int8 multiply-accumulate with zero-point compensation, bias and Q15
// requantization to saturated int8.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | weight, activation, bias, is_last
//  out      | out_valid / out_ready| result_value, one per last word
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready always 1)
//
// the front takes one word per cycle while the two-entry queue has room
// the requantizer runs each sum through comp, bias, a 17 x 32 partial-product
// multiplier loop, round and emit, and pops the next sum only when idle; a
// held result in the output register stalls it, and the front once the queue
// fills; reset clears the sums, queue, sequencer and registers to defaults
module int8_dot_product_requantizer
	import idpr_pkg::*;
#(
	parameter int ACC_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [7:0]  weight_value,
	input  logic signed [7:0]  activation_value,
	input  logic signed [31:0] bias_value,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [7:0]  result_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int Q_WIDTH = 2 * ACC_BITS + BIAS_BITS;

	cfg_regs_t               cfg_q;
	logic                    q_push;
	logic [Q_WIDTH-1:0]      q_push_data;
	logic                    q_full;
	logic                    q_pop;
	logic [Q_WIDTH-1:0]      q_pop_data;
	logic                    q_not_empty;
	logic [Q_CNT_BITS-1:0]   q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_zero       <= '0;
			cfg_q.output_zero      <= '0;
			cfg_q.scale_multiplier <= SCALE_RESET;
			cfg_q.bias_enable      <= 1'b0;
			cfg_q.relu_enable      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INPUT_ZERO:  cfg_q.input_zero       <= cfg_data[7:0];
				REG_OUTPUT_ZERO: cfg_q.output_zero      <= cfg_data[7:0];
				REG_SCALE_MULT:  cfg_q.scale_multiplier <= cfg_data;
				REG_BIAS_ENABLE: cfg_q.bias_enable      <= cfg_data[0];
				REG_RELU_ENABLE: cfg_q.relu_enable      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	idpr_front #(
		.ACC_BITS(ACC_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.weight_value     (weight_value),
		.activation_value (activation_value),
		.bias_value       (bias_value),
		.is_last          (is_last),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_data           (q_push_data)
	);

	idpr_queue #(
		.WIDTH(Q_WIDTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	idpr_back #(
		.ACC_BITS(ACC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.q_data       (q_pop_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value)
	);

`include "int8_dot_product_requantizer_macros.svh"

	`IDPR_ASSERT_NOW(a_pop_not_empty, q_pop, q_count != '0, "pop from empty queue")
	`IDPR_ASSERT_NOW(a_count_bound, 1'b1, q_count <= Q_CNT_BITS'(Q_DEPTH), "queue overfilled")
	`IDPR_ASSERT_NOW(a_push_on_last, q_push, in_valid && in_ready && is_last, "stray push")
	`IDPR_ASSERT_NEXT(a_push_counted, q_push && !q_pop, q_count != '0, "push not counted")

endmodule
